// ----- hw/rtl/imh_pkg.sv -----
package imh_pkg;

  localparam int unsigned NODES    = 64;
  localparam int unsigned SLOTS    = 4;
  localparam int unsigned CAPACITY = NODES * SLOTS;
  localparam int unsigned POS_W    = $clog2(CAPACITY);
  localparam int unsigned CNT_W    = $clog2(CAPACITY + 1);

  localparam logic [2:0] ST_INSERTED  = 3'd0;
  localparam logic [2:0] ST_UPDATED   = 3'd1;
  localparam logic [2:0] ST_REJECTED  = 3'd2;
  localparam logic [2:0] ST_EXTRACTED = 3'd3;
  localparam logic [2:0] ST_EMPTY     = 3'd4;

  localparam logic FUNC_INSERT  = 1'b0;
  localparam logic FUNC_EXTRACT = 1'b1;

  typedef struct packed {
    logic        func;
    logic [5:0]  node;
    logic [1:0]  slot;
    logic [31:0] key_value;
  } in_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [5:0]  out_node;
    logic [1:0]  out_slot;
    logic [31:0] out_value;
    logic [8:0]  occupancy;
  } out_t;

  typedef struct packed {
    logic [5:0]  node;
    logic [1:0]  slot;
    logic [31:0] value;
  } ent_t;

  typedef enum logic [3:0] {
    OP_NONE, OP_LATCH, OP_POS_RD, OP_UPD_RD, OP_UPD_LD, OP_APPEND, OP_UP_RD, OP_UP_STEP,
    OP_PLACE, OP_ROOT_RD, OP_ROOT_LD, OP_LAST_RD, OP_LAST_LD, OP_DN_RDL, OP_DN_RDR,
    OP_DN_STEP
  } op_e;

  typedef struct packed {
    op_e op;
  } cmd_t;

  typedef struct packed {
    logic func;
    logic reject;     // full or key out of range
    logic present;
    logic empty;
    logic hole_root;
    logic up_swap;
    logic no_left;
    logic dn_move;
  } stat_t;

  function automatic logic [POS_W-1:0] key_of(logic [5:0] node, logic [1:0] slot);
    return POS_W'(32'(node) * SLOTS + 32'(slot));
  endfunction

endpackage

// ----- hw/rtl/indexed_min_heap_decrease_key_core.sv -----
// Channel   Dir  Handshake            Payload
// command   in   start & !busy        in_i  (func, node, slot, key_value)
// result    out  done_o, one cycle    res_o (status, out_node, out_slot, out_value, occupancy)
//
// Insert appends at the end and climbs; update first looks up the key's heap slot, then
// climbs. Extract takes the root, moves the last entry there and descends until no child
// is smaller; it ends at once when the last entry leaves. Each level costs a registered
// heap read (two when descending), a compare and a write. Reject/empty go straight to done.
// Reset clears the count and the 256 key-present bits at once; no clearing pass.
// The receiver cannot stall: res_o is valid only in the cycle done_o is high.
module indexed_min_heap_decrease_key_core (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start,
  output logic          busy,
  input  imh_pkg::in_t  in_i,
  output logic          done_o,
  output imh_pkg::out_t res_o
);

  imh_pkg::cmd_t  cmd;
  imh_pkg::stat_t stat;
  imh_pkg::ent_t  out_ent;
  logic [2:0]     status;
  logic [8:0]     occupancy;

  imh_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start    (start),
    .busy     (busy),
    .done_o   (done_o),
    .status_o (status),
    .stat_i   (stat),
    .cmd_o    (cmd)
  );

  imh_dpath u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_i),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .out_ent_o   (out_ent),
    .occupancy_o (occupancy)
  );

  assign res_o.status    = status;
  assign res_o.out_node  = out_ent.node;
  assign res_o.out_slot  = out_ent.slot;
  assign res_o.out_value = out_ent.value;
  assign res_o.occupancy = occupancy;

  a_done_busy: assert property (@(posedge clk_i) disable iff (!rst_ni) done_o |-> busy)
    else $error("result strobe outside a transaction");

  a_done_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni) done_o |=> !done_o)
    else $error("result strobe longer than one cycle");

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("accepted transaction did not raise busy");

  a_occ_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (32'(res_o.occupancy) <= imh_pkg::CAPACITY))
    else $error("occupancy beyond capacity");

  a_reject_nochange: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && (res_o.status == imh_pkg::ST_REJECTED || res_o.status == imh_pkg::ST_EMPTY))
    |-> (res_o.out_value == '0 && res_o.out_node == '0))
    else $error("non-extract result carries entry data");

endmodule

// ----- hw/rtl/imh_dpath.sv -----
module imh_dpath (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  imh_pkg::in_t    in_i,
  input  imh_pkg::cmd_t   cmd_i,
  output imh_pkg::stat_t  stat_o,
  output imh_pkg::ent_t   out_ent_o,
  output logic [8:0]      occupancy_o
);

  localparam int unsigned IW = imh_pkg::POS_W + 2;

  imh_pkg::ent_t heap_mem [imh_pkg::CAPACITY];
  logic [imh_pkg::POS_W-1:0] pos_mem [imh_pkg::CAPACITY];

  imh_pkg::ent_t e_q, lent_q, out_q, rd_q;
  logic [imh_pkg::POS_W-1:0] key_q, i_q, prd_q;
  logic [imh_pkg::CNT_W-1:0] cnt_q;
  logic                      func_q, bad_q;
  logic [imh_pkg::CAPACITY-1:0] valid_q;

  logic [imh_pkg::POS_W-1:0] parent, clamp, l_idx, r_idx;
  logic [IW-1:0]             lw, rw, cnt_ext;
  logic                      l_ok, r_ok, bl, br;
  logic [31:0]               bv;
  imh_pkg::ent_t             child;

  logic                      rd_en, wr_en, pw_en;
  logic [imh_pkg::POS_W-1:0] rd_addr, wr_addr, pw_addr, pw_data;
  imh_pkg::ent_t             wr_data;

  assign parent  = (i_q - 1'b1) >> 1;
  assign lw      = IW'({i_q, 1'b1});
  assign rw      = lw + 1'b1;
  assign cnt_ext = IW'(cnt_q);
  assign l_ok    = lw < cnt_ext;
  assign r_ok    = rw < cnt_ext;
  assign l_idx   = lw[imh_pkg::POS_W-1:0];
  assign r_idx   = rw[imh_pkg::POS_W-1:0];
  assign clamp   = (imh_pkg::CNT_W'(prd_q) >= cnt_q) ? '0 : prd_q;

  // sift-down pick: ties never move
  assign bl    = lent_q.value < e_q.value;
  assign bv    = bl ? lent_q.value : e_q.value;
  assign br    = r_ok && (rd_q.value < bv);
  assign child = br ? rd_q : lent_q;

  assign stat_o.func      = func_q;
  assign stat_o.reject    = bad_q || (cnt_q >= imh_pkg::CNT_W'(imh_pkg::CAPACITY));
  assign stat_o.present   = valid_q[key_q];
  assign stat_o.empty     = cnt_q == '0;
  assign stat_o.hole_root = i_q == '0;
  assign stat_o.up_swap   = rd_q.value > e_q.value;
  assign stat_o.no_left   = !l_ok;
  assign stat_o.dn_move   = bl || br;

  assign out_ent_o   = out_q;
  assign occupancy_o = 9'(cnt_q);

  always_comb begin
    rd_en   = 1'b0;
    rd_addr = '0;
    wr_en   = 1'b0;
    wr_addr = i_q;
    wr_data = e_q;
    pw_en   = 1'b0;
    pw_addr = imh_pkg::key_of(e_q.node, e_q.slot);
    pw_data = i_q;
    unique case (cmd_i.op)
      imh_pkg::OP_UPD_RD: begin
        rd_en   = 1'b1;
        rd_addr = clamp;
      end
      imh_pkg::OP_UP_RD: begin
        rd_en   = 1'b1;
        rd_addr = parent;
      end
      imh_pkg::OP_ROOT_RD: begin
        rd_en = 1'b1;
      end
      imh_pkg::OP_LAST_RD: begin
        rd_en   = 1'b1;
        rd_addr = imh_pkg::POS_W'(cnt_q);
      end
      imh_pkg::OP_DN_RDL: begin
        rd_en   = 1'b1;
        rd_addr = l_idx;
      end
      imh_pkg::OP_DN_RDR: begin
        rd_en   = 1'b1;
        rd_addr = r_idx;
      end
      imh_pkg::OP_UP_STEP: begin
        wr_en   = 1'b1;
        wr_data = rd_q;
        pw_en   = 1'b1;
        pw_addr = imh_pkg::key_of(rd_q.node, rd_q.slot);
      end
      imh_pkg::OP_DN_STEP: begin
        wr_en   = 1'b1;
        wr_data = child;
        pw_en   = 1'b1;
        pw_addr = imh_pkg::key_of(child.node, child.slot);
      end
      imh_pkg::OP_PLACE: begin
        wr_en = 1'b1;
        pw_en = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      rd_q <= heap_mem[rd_addr];
    end
    if (wr_en) begin
      heap_mem[wr_addr] <= wr_data;
    end
    if (cmd_i.op == imh_pkg::OP_POS_RD) begin
      prd_q <= pos_mem[key_q];
    end
    if (pw_en) begin
      pos_mem[pw_addr] <= pw_data;
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (cmd_i.op)
      imh_pkg::OP_LATCH: begin
        e_q    <= '{node: in_i.node, slot: in_i.slot, value: in_i.key_value};
        key_q  <= imh_pkg::key_of(in_i.node, in_i.slot);
        func_q <= in_i.func;
        bad_q  <= (32'(in_i.node) >= imh_pkg::NODES) || (32'(in_i.slot) >= imh_pkg::SLOTS);
        out_q  <= '0;
      end
      imh_pkg::OP_UPD_RD:  i_q <= clamp;
      imh_pkg::OP_UPD_LD: begin
        e_q.node <= rd_q.node;
        e_q.slot <= rd_q.slot;
      end
      imh_pkg::OP_APPEND:  i_q <= imh_pkg::POS_W'(cnt_q);
      imh_pkg::OP_UP_STEP: i_q <= parent;
      imh_pkg::OP_ROOT_LD: out_q <= rd_q;
      imh_pkg::OP_LAST_LD: begin
        e_q <= rd_q;
        i_q <= '0;
      end
      imh_pkg::OP_DN_RDR:  lent_q <= rd_q;
      imh_pkg::OP_DN_STEP: i_q <= br ? r_idx : l_idx;
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q   <= '0;
      valid_q <= '0;
    end else begin
      if (cmd_i.op == imh_pkg::OP_APPEND) begin
        cnt_q          <= cnt_q + 1'b1;
        valid_q[key_q] <= 1'b1;
      end else if (cmd_i.op == imh_pkg::OP_ROOT_LD) begin
        cnt_q <= cnt_q - 1'b1;
        valid_q[imh_pkg::key_of(rd_q.node, rd_q.slot)] <= 1'b0;
      end
    end
  end

endmodule

// ----- hw/rtl/imh_ctrl.sv -----
module imh_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start,
  output logic            busy,
  output logic            done_o,
  output logic [2:0]      status_o,
  input  imh_pkg::stat_t  stat_i,
  output imh_pkg::cmd_t   cmd_o
);

  typedef enum logic [13:0] {
    S_IDLE   = 14'b00000000000001,
    S_DECODE = 14'b00000000000010,
    S_UPD_A  = 14'b00000000000100,
    S_UPD_B  = 14'b00000000001000,
    S_UP_A   = 14'b00000000010000,
    S_UP_B   = 14'b00000000100000,
    S_PLACE  = 14'b00000001000000,
    S_EX_A   = 14'b00000010000000,
    S_EX_B   = 14'b00000100000000,
    S_EX_C   = 14'b00001000000000,
    S_DN_A   = 14'b00010000000000,
    S_DN_B   = 14'b00100000000000,
    S_DN_C   = 14'b01000000000000,
    S_DONE   = 14'b10000000000000
  } state_e;

  state_e     state_q, state_d;
  logic [2:0] status_q, status_d;

  assign busy     = state_q != S_IDLE;
  assign done_o   = state_q == S_DONE;
  assign status_o = status_q;

  always_comb begin
    state_d    = state_q;
    status_d   = status_q;
    cmd_o.op   = imh_pkg::OP_NONE;
    unique case (state_q)
      S_IDLE: begin
        if (start) begin
          cmd_o.op = imh_pkg::OP_LATCH;
          state_d  = S_DECODE;
        end
      end
      S_DECODE: begin
        if (stat_i.func == imh_pkg::FUNC_INSERT) begin
          if (stat_i.reject) begin
            status_d = imh_pkg::ST_REJECTED;
            state_d  = S_DONE;
          end else if (stat_i.present) begin
            status_d = imh_pkg::ST_UPDATED;
            cmd_o.op = imh_pkg::OP_POS_RD;
            state_d  = S_UPD_A;
          end else begin
            status_d = imh_pkg::ST_INSERTED;
            cmd_o.op = imh_pkg::OP_APPEND;
            state_d  = S_UP_A;
          end
        end else if (stat_i.empty) begin
          status_d = imh_pkg::ST_EMPTY;
          state_d  = S_DONE;
        end else begin
          status_d = imh_pkg::ST_EXTRACTED;
          cmd_o.op = imh_pkg::OP_ROOT_RD;
          state_d  = S_EX_A;
        end
      end
      S_UPD_A: begin
        cmd_o.op = imh_pkg::OP_UPD_RD;
        state_d  = S_UPD_B;
      end
      S_UPD_B: begin
        cmd_o.op = imh_pkg::OP_UPD_LD;
        state_d  = S_UP_A;
      end
      S_UP_A: begin
        if (stat_i.hole_root) begin
          state_d = S_PLACE;
        end else begin
          cmd_o.op = imh_pkg::OP_UP_RD;
          state_d  = S_UP_B;
        end
      end
      S_UP_B: begin
        if (stat_i.up_swap) begin
          cmd_o.op = imh_pkg::OP_UP_STEP;
          state_d  = S_UP_A;
        end else begin
          state_d = S_PLACE;
        end
      end
      S_PLACE: begin
        cmd_o.op = imh_pkg::OP_PLACE;
        state_d  = S_DONE;
      end
      S_EX_A: begin
        cmd_o.op = imh_pkg::OP_ROOT_LD;
        state_d  = S_EX_B;
      end
      S_EX_B: begin
        if (stat_i.empty) begin
          state_d = S_DONE;
        end else begin
          cmd_o.op = imh_pkg::OP_LAST_RD;
          state_d  = S_EX_C;
        end
      end
      S_EX_C: begin
        cmd_o.op = imh_pkg::OP_LAST_LD;
        state_d  = S_DN_A;
      end
      S_DN_A: begin
        if (stat_i.no_left) begin
          state_d = S_PLACE;
        end else begin
          cmd_o.op = imh_pkg::OP_DN_RDL;
          state_d  = S_DN_B;
        end
      end
      S_DN_B: begin
        cmd_o.op = imh_pkg::OP_DN_RDR;
        state_d  = S_DN_C;
      end
      S_DN_C: begin
        if (stat_i.dn_move) begin
          cmd_o.op = imh_pkg::OP_DN_STEP;
          state_d  = S_DN_A;
        end else begin
          state_d = S_PLACE;
        end
      end
      S_DONE: begin
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      status_q <= imh_pkg::ST_INSERTED;
    end else begin
      state_q  <= state_d;
      status_q <= status_d;
    end
  end

endmodule
